// ===== rtl/modified_laplacian_focus_measure_assert.svh =====
// Assertion macros for the focus measure RTL.
// Each expects clk and arst_n in scope.
`ifndef MODIFIED_LAPLACIAN_FOCUS_MEASURE_ASSERT_SVH
`define MODIFIED_LAPLACIAN_FOCUS_MEASURE_ASSERT_SVH

// Same-cycle implication.
`define MLFM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MLFM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mlfm_pkg.sv =====
package mlfm_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 12;
	localparam int PIX_W      = 8;
	localparam int FOCUS_W    = 10;
	localparam int FWIDTH_W   = 11;
	localparam int FHEIGHT_W  = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	// one result word
	typedef struct packed {
		logic [FOCUS_W-1:0] focus;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic               frame_end;
	} res_t;

	// |2*mid - a - b|
	function automatic logic [PIX_W:0] absdiff2(input logic [PIX_W-1:0] mid,
			input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
		logic [PIX_W:0] twice;
		logic [PIX_W:0] sum;
		twice = {mid, 1'b0};
		sum   = {1'b0, a} + {1'b0, b};
		return (twice >= sum) ? (twice - sum) : (sum - twice);
	endfunction

	// modified Laplacian with mirrored borders; corners give zero
	function automatic logic [FOCUS_W-1:0] measure(input logic top, input logic bottom,
			input logic le, input logic re,
			input logic [PIX_W-1:0] up_px, input logic [PIX_W-1:0] lf_px,
			input logic [PIX_W-1:0] mid_px, input logic [PIX_W-1:0] rt_px,
			input logic [PIX_W-1:0] dn_px);
		logic [PIX_W-1:0]   u;
		logic [PIX_W-1:0]   d;
		logic [PIX_W-1:0]   l;
		logic [PIX_W-1:0]   r;
		logic [FOCUS_W-1:0] res;
		u = up_px;
		d = dn_px;
		l = lf_px;
		r = rt_px;
		if (top) u = dn_px;
		if (bottom) d = u;
		if (le) l = rt_px;
		if (re) r = l;
		if ((top || bottom) && (le || re)) begin
			res = '0;
		end else begin
			res = FOCUS_W'(absdiff2(mid_px, l, r)) + FOCUS_W'(absdiff2(mid_px, u, d));
		end
		return res;
	endfunction

endpackage

// ===== rtl/mlfm_ram.sv =====
module mlfm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/modified_laplacian_focus_measure.sv =====
// channel  | handshake            | word
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | pixel
// out      | out_valid / out_ready| focus_value, out_row, out_col, item_last, frame_last
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (cfg_ready always high)
//
// One pixel per clock while out_ready holds; words pass stage 1 and then the group register.
// Pace is set by the one line buffer RAM port pair: read at accept, write as stage 1 retires.
// Last-row or last-column pixels make two words, four at both; the out port then limits input.
// arst_n clears counters, window, geometry (640 x 480) and valids; RAM needs no clear.
// A stalled out port holds one word group plus one pixel in stage 1 before in_ready drops.
`include "modified_laplacian_focus_measure_assert.svh"

module modified_laplacian_focus_measure (
	input  logic                             clk,
	input  logic                             arst_n,
	// pixel in
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mlfm_pkg::PIX_W-1:0]       pixel,
	// result out
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mlfm_pkg::FOCUS_W-1:0]     focus_value,
	output logic [mlfm_pkg::ROW_W-1:0]       out_row,
	output logic [mlfm_pkg::COL_W-1:0]       out_col,
	output logic                             item_last,
	output logic                             frame_last,
	// config writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mlfm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mlfm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import mlfm_pkg::*;

	// geometry registers
	logic [FWIDTH_W-1:0]  frame_width_q;
	logic [FHEIGHT_W-1:0] frame_height_q;

	// raster position of the next pixel
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// clamped geometry and position
	logic [FWIDTH_W-1:0]  w_eff;
	logic [FHEIGHT_W-1:0] h_eff;
	logic [COL_W-1:0]     wm1;
	logic [ROW_W-1:0]     hm1;
	logic [COL_W-1:0]     c_cur;
	logic [ROW_W-1:0]     r_cur;
	logic                 last_col;
	logic                 last_row;

	logic in_acc;
	logic out_acc;

	// stage 1: pixel waiting on its line buffer read
	logic             valid_s1;
	logic [PIX_W-1:0] px_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             res_en_s1;   // c >= 1 and r >= 1
	logic             lrow_s1;
	logic             lcol_s1;
	logic             top_s1;      // row above is row 0
	logic             lft_s1;      // column left is column 0
	logic             s1_adv;

	// 3x2 window of earlier pixels (oldest pixel, two rows and two columns back, not needed)
	logic [PIX_W-1:0] wp0_q, wp1_q, wp2_q, wp3_q, wp4_q;

	// line buffers: {two rows back, one row back}
	logic [2*PIX_W-1:0] lb_rd;
	logic [PIX_W-1:0]   a_px;
	logic [PIX_W-1:0]   b_px;

	// output word group, shifted out from entry 0
	res_t       grp_q [4];
	logic [2:0] grp_cnt_q;
	logic       grp_free;
	logic       grp_load;
	res_t       new_grp [4];
	logic [2:0] new_cnt;

	logic [FOCUS_W-1:0] f1, f2, f3;
	logic [ROW_W-1:0]   rm1;
	logic [COL_W-1:0]   cm1;

	// geometry clamp and position saturation
	always_comb begin
		if (frame_width_q < FWIDTH_W'(2)) begin
			w_eff = FWIDTH_W'(2);
		end else if (frame_width_q > FWIDTH_W'(MAX_WIDTH)) begin
			w_eff = FWIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = frame_width_q;
		end
		if (frame_height_q < FHEIGHT_W'(2)) begin
			h_eff = FHEIGHT_W'(2);
		end else begin
			h_eff = frame_height_q;
		end
		wm1      = COL_W'(w_eff - 1'b1);
		hm1      = ROW_W'(h_eff - 1'b1);
		c_cur    = (col_q < wm1) ? col_q : wm1;
		r_cur    = (row_q < hm1) ? row_q : hm1;
		last_col = (c_cur == wm1);
		last_row = (r_cur == hm1);
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FWIDTH_W'(640);
			frame_height_q <= FHEIGHT_W'(480);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FWIDTH_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[FHEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshakes
	assign grp_free = (grp_cnt_q == 3'd0) || ((grp_cnt_q == 3'd1) && out_ready);
	assign s1_adv   = valid_s1 && (!res_en_s1 || grp_free);
	assign grp_load = s1_adv && res_en_s1;
	assign in_ready = !valid_s1 || s1_adv;
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;

	// raster counters advance at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : r_cur + 1'b1;
			end else begin
				col_q <= c_cur + 1'b1;
				row_q <= r_cur;
			end
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1     <= pixel;
			col_s1    <= c_cur;
			row_s1    <= r_cur;
			res_en_s1 <= (c_cur != '0) && (r_cur != '0);
			lrow_s1   <= last_row;
			lcol_s1   <= last_col;
			top_s1    <= (r_cur == ROW_W'(1));
			lft_s1    <= (c_cur == COL_W'(1));
		end
	end

	// line buffers: read at accept, write back when stage 1 retires.
	// Consecutive pixels hit different columns, so no read/write clash.
	mlfm_ram #(
		.WIDTH(2*PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_lbuf (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data ({b_px, px_s1}),
		.rd_en   (in_acc),
		.rd_addr (c_cur),
		.rd_data (lb_rd)
	);

	assign a_px = lb_rd[2*PIX_W-1:PIX_W];
	assign b_px = lb_rd[PIX_W-1:0];

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp0_q <= '0;
			wp1_q <= '0;
			wp2_q <= '0;
			wp3_q <= '0;
			wp4_q <= '0;
		end else if (s1_adv) begin
			wp0_q <= px_s1;
			wp1_q <= wp0_q;
			wp2_q <= b_px;
			wp3_q <= wp2_q;
			wp4_q <= a_px;
		end
	end

	// build the word group for this pixel:
	//   upper-left result always; lower-left on the last row;
	//   upper-right at the last column; lower-right (corner, zero) at both
	always_comb begin
		rm1 = row_s1 - 1'b1;
		cm1 = col_s1 - 1'b1;
		f1  = measure(top_s1, 1'b0, lft_s1, 1'b0, wp4_q, wp3_q, wp2_q, b_px, wp0_q);
		f2  = measure(1'b0, 1'b1, lft_s1, 1'b0, wp2_q, wp1_q, wp0_q, px_s1, '0);
		f3  = measure(top_s1, 1'b0, 1'b0, 1'b1, a_px, wp2_q, b_px, '0, px_s1);

		new_grp[0] = '{focus: f1, row: rm1, col: cm1, frame_end: 1'b0};
		if (lrow_s1) begin
			new_grp[1] = '{focus: f2, row: row_s1, col: cm1, frame_end: 1'b0};
		end else begin
			new_grp[1] = '{focus: f3, row: rm1, col: col_s1, frame_end: 1'b0};
		end
		new_grp[2] = '{focus: f3, row: rm1, col: col_s1, frame_end: 1'b0};
		new_grp[3] = '{focus: '0, row: row_s1, col: col_s1, frame_end: 1'b1};

		if (lrow_s1 && lcol_s1) begin
			new_cnt = 3'd4;
		end else if (lrow_s1 || lcol_s1) begin
			new_cnt = 3'd2;
		end else begin
			new_cnt = 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_cnt_q <= '0;
		end else if (grp_load) begin
			grp_cnt_q <= new_cnt;
		end else if (out_acc) begin
			grp_cnt_q <= grp_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load) begin
			grp_q <= new_grp;
		end else if (out_acc) begin
			grp_q[0] <= grp_q[1];
			grp_q[1] <= grp_q[2];
			grp_q[2] <= grp_q[3];
		end
	end

	assign out_valid   = (grp_cnt_q != 3'd0);
	assign focus_value = grp_q[0].focus;
	assign out_row     = grp_q[0].row;
	assign out_col     = grp_q[0].col;
	assign frame_last  = grp_q[0].frame_end;
	assign item_last   = (grp_cnt_q == 3'd1);

	// checks
	`MLFM_ASSERT_NOW(a_frame_end_closes_item, out_valid && frame_last, item_last, "frame_last without item_last")
	`MLFM_ASSERT_NEXT(a_accept_fills_s1, in_acc, valid_s1, "accepted pixel lost before stage 1")
	`MLFM_ASSERT_NEXT(a_s1_holds, valid_s1 && !s1_adv, valid_s1 && $stable(px_s1) && $stable(col_s1), "stalled stage 1 changed")
	`MLFM_ASSERT_NOW(a_grp_bound, out_valid, grp_cnt_q <= 3'd4, "word group count overflow")

endmodule
